@@ rtl/core/tlik_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics: shared package
// Number formats, status codes, register indexes, CORDIC angle table and the
// pipeline word types of the solver.
// ----------------------------------------------------------------------------
package tlik_pkg;

    // Fixed-point format: positions and lengths are Q3.FRAC_BITS, angles are Q2.FRAC_BITS.
    localparam int FRAC_BITS = 12;
    localparam int POS_W     = 16;
    localparam int LEN_W     = 15;
    localparam int SHO_W     = 15;
    localparam int ELB_W     = 14;
    localparam int STAT_W    = 2;

    // Magnitude of the elbow cosine and sine, 0 to 1.0.
    localparam int CM_W   = FRAC_BITS + 1;
    localparam int C_W    = CM_W + 1;
    localparam int RAD_W  = 2 * FRAC_BITS + 1;
    localparam int SQT_W  = RAD_W + 2;

    // Law of cosines terms.
    localparam int SQ_W   = 2 * POS_W - 1;
    localparam int LSQ_W  = 2 * LEN_W;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = LSQ_W + 1;
    localparam int NN_W   = 44;

    // Shoulder terms.
    localparam int K1_W   = 29;
    localparam int K2_W   = 28;
    localparam int P_W    = 45;
    localparam int CIN_W  = 46;

    // CORDIC datapath.
    localparam int M_W          = 51;
    localparam int NX_W         = 52;
    localparam int CX_W         = 55;
    localparam int Z_W          = 34;
    localparam int CORDIC_ITERS = 30;
    localparam int NORM_STAGES  = 3;
    localparam int CORDIC_LAT   = 1 + NORM_STAGES + 1 + CORDIC_ITERS;
    localparam int ZQ_W         = 16;

    localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
    // Pi rounded to the output format.
    localparam int PI_QF = 12868;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b1;
    localparam logic [LEN_W-1:0] UPPER_RESET = 15'd4096;
    localparam logic [LEN_W-1:0] LOWER_RESET = 15'd2048;

    typedef enum logic [STAT_W-1:0] {
        STAT_SOLVED = 2'd0,
        STAT_REACH  = 2'd1,
        STAT_ORIGIN = 2'd2
    } status_t;

    // Arctangent of 2^-i in Q.30 radians.
    function automatic logic signed [Z_W-1:0] atan_step(input int unsigned idx);
        logic signed [Z_W-1:0] step;
        unique case (idx)
            0:       step = 34'sd843314857;
            1:       step = 34'sd497837829;
            2:       step = 34'sd263043837;
            3:       step = 34'sd133525159;
            4:       step = 34'sd67021687;
            5:       step = 34'sd33543516;
            6:       step = 34'sd16775852;
            7:       step = 34'sd8388437;
            8:       step = 34'sd4194283;
            9:       step = 34'sd2097149;
            10:      step = 34'sd1048576;
            default: step = Z_W'(longint'(1) << (CORDIC_ITERS - idx));
        endcase
        return step;
    endfunction

    // Stage words of the solver pipeline.
    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SQ_W-1:0]         xx;
        logic [SQ_W-1:0]         yy;
        logic [LSQ_W-1:0]        luu;
        logic [LSQ_W-1:0]        lll;
        logic [LSQ_W-1:0]        lul;
        logic [LEN_W-1:0]        lu;
        logic [LEN_W-1:0]        ll;
        logic                    origin;
    } sq_word_t;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [NUM_W-1:0] num;
        logic [LSQ_W-1:0]        lul;
        logic [LEN_W-1:0]        lu;
        logic [LEN_W-1:0]        ll;
        logic                    origin;
    } num_word_t;

    typedef struct packed {
        logic                    valid;
        logic [DEN_W-1:0]        r;
        logic [CM_W-1:0]         nrest;
        logic [CM_W-1:0]         q;
        logic [DEN_W-1:0]        den;
        logic                    neg;
        logic                    oor;
        logic [LEN_W-1:0]        lu;
        logic [LEN_W-1:0]        ll;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    origin;
    } div_word_t;

    typedef struct packed {
        logic                    valid;
        logic [RAD_W-1:0]        rem;
        logic [CM_W-1:0]         root;
        logic signed [C_W-1:0]   c;
        logic [LEN_W-1:0]        lu;
        logic [LEN_W-1:0]        ll;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        status_t                 status;
    } root_word_t;

    typedef struct packed {
        logic                    valid;
        logic signed [K1_W-1:0]  k1;
        logic [K2_W-1:0]         k2;
        logic signed [C_W-1:0]   c;
        logic [CM_W-1:0]         s;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        status_t                 status;
    } k_word_t;

    typedef struct packed {
        logic                    valid;
        logic signed [P_W-1:0]   p1;
        logic signed [P_W-1:0]   p2;
        logic signed [P_W-1:0]   p3;
        logic signed [P_W-1:0]   p4;
        logic signed [C_W-1:0]   c;
        logic [CM_W-1:0]         s;
        status_t                 status;
    } prod_word_t;

    typedef struct packed {
        logic                    valid;
        logic signed [CIN_W-1:0] sy;
        logic signed [CIN_W-1:0] sx;
        logic signed [CIN_W-1:0] ey;
        logic signed [CIN_W-1:0] ex;
        status_t                 status;
    } vec_word_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } side_word_t;

    typedef struct packed {
        logic signed [NX_W-1:0] x;
        logic signed [NX_W-1:0] y;
        logic [M_W-1:0]         m;
        logic                   zero;
    } norm_word_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } iter_word_t;

endpackage
`default_nettype wire

@@ rtl/core/tlik_atan2.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined CORDIC atan2
// Normalizes the vector, folds the left half-plane by pi, then runs one
// vectoring iteration per stage. Result is a Q.30 angle, zero for a zero vector.
// ----------------------------------------------------------------------------
module tlik_atan2
    import tlik_pkg::*;
(
    input  wire                     clk,
    input  wire                     en,
    input  wire signed [CIN_W-1:0]  y_in,
    input  wire signed [CIN_W-1:0]  x_in,
    output logic signed [Z_W-1:0]   z_out
);

    norm_word_t nm_reg [0:NORM_STAGES];
    iter_word_t it_reg [0:CORDIC_ITERS];

    logic [CIN_W-1:0] ax;
    logic [CIN_W-1:0] ay;

    // Magnitudes: their OR has the same leading one as the larger of the two.
    always_comb
    begin
        ax = x_in[CIN_W-1] ? CIN_W'(-x_in) : CIN_W'(x_in);
        ay = y_in[CIN_W-1] ? CIN_W'(-y_in) : CIN_W'(y_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_reg[0].x    <= NX_W'(x_in);
            nm_reg[0].y    <= NX_W'(y_in);
            nm_reg[0].m    <= M_W'(ax | ay);
            nm_reg[0].zero <= ((ax | ay) == '0);
        end
    end

    // Normalization: two conditional left shifts per stage until the leading
    // one reaches the top bit of the window.
    for (genvar n = 0; n < NORM_STAGES; n++)
    begin : g_norm
        localparam int SH1 = 32 >> (2 * n);
        localparam int SH2 = 16 >> (2 * n);
        norm_word_t nm_next;

        always_comb
        begin
            nm_next = nm_reg[n];
            if (nm_next.m[M_W-1 -: SH1] == '0)
            begin
                nm_next.m = nm_next.m << SH1;
                nm_next.x = nm_next.x <<< SH1;
                nm_next.y = nm_next.y <<< SH1;
            end
            if (nm_next.m[M_W-1 -: SH2] == '0)
            begin
                nm_next.m = nm_next.m << SH2;
                nm_next.x = nm_next.x <<< SH2;
                nm_next.y = nm_next.y <<< SH2;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nm_reg[n+1] <= nm_next;
            end
        end
    end

    // Left half-plane: rotate by pi so that the iterations see x >= 0.
    logic signed [CX_W-1:0] xe;
    logic signed [CX_W-1:0] ye;
    iter_word_t             rot_next;

    always_comb
    begin
        xe = CX_W'(nm_reg[NORM_STAGES].x);
        ye = CX_W'(nm_reg[NORM_STAGES].y);
        rot_next.zero = nm_reg[NORM_STAGES].zero;
        if (xe < 0)
        begin
            rot_next.x = -xe;
            rot_next.y = -ye;
            rot_next.z = (ye >= 0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            rot_next.x = xe;
            rot_next.y = ye;
            rot_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[0] <= rot_next;
        end
    end

    // Vectoring iterations, one per stage.
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        localparam logic signed [Z_W-1:0] STEP = atan_step(i);
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        iter_word_t             it_next;

        always_comb
        begin
            xs = it_reg[i].x >>> i;
            ys = it_reg[i].y >>> i;
            it_next.zero = it_reg[i].zero;
            if (it_reg[i].y >= 0)
            begin
                it_next.x = it_reg[i].x + ys;
                it_next.y = it_reg[i].y - xs;
                it_next.z = it_reg[i].z + STEP;
            end
            else
            begin
                it_next.x = it_reg[i].x - ys;
                it_next.y = it_reg[i].y + xs;
                it_next.z = it_reg[i].z - STEP;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_reg[i+1] <= it_next;
            end
        end
    end

    assign z_out = it_reg[CORDIC_ITERS].zero ? '0 : it_reg[CORDIC_ITERS].z;

endmodule
`default_nettype wire

@@ rtl/core/two_link_inverse_kinematics_top.sv @@
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or its word is taken, so a stall holds every stage.
// Division, square root and the two CORDIC lanes are unrolled one bit or one
// iteration per stage. Reset (rst_n low) clears all valid bits and loads the
// link lengths with 1.0 and 0.5.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-link planar arm inverse kinematics
// Law of cosines for the elbow, exact square root for its sine, and CORDIC
// atan2 for both joint angles, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_top
    import tlik_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [31:0]          s_tdata,   // target_x[15:0], target_y[31:16]
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [31:0]          m_tdata,   // shoulder_angle[14:0], elbow_angle[28:15]
    output logic [STAT_W-1:0]    m_tuser,   // solve_status[1:0]
    input  wire                  cfg_we,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [LEN_W-1:0]     cfg_data
);

    logic adv;

    // Link length registers.
    logic [LEN_W-1:0] upper_len_reg;
    logic [LEN_W-1:0] lower_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_len_reg <= UPPER_RESET;
            lower_len_reg <= LOWER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UPPER: upper_len_reg <= cfg_data;
                REG_LOWER: lower_len_reg <= cfg_data;
                default:   upper_len_reg <= upper_len_reg;
            endcase
        end
    end

    // Handshake: every stage moves together when the output can take a word.
    logic                    out_valid_reg;
    logic signed [SHO_W-1:0] out_sho_reg;
    logic [ELB_W-1:0]        out_elb_reg;
    status_t                 out_stat_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Stage 1: squares and link products.
    sq_word_t                s1_reg;
    sq_word_t                s1_next;
    logic [LEN_W-1:0]        lu_eff;
    logic [LEN_W-1:0]        ll_eff;
    logic signed [2*POS_W-1:0] xx_full;
    logic signed [2*POS_W-1:0] yy_full;

    always_comb
    begin
        lu_eff = (upper_len_reg == '0) ? LEN_W'(1) : upper_len_reg;
        ll_eff = (lower_len_reg == '0) ? LEN_W'(1) : lower_len_reg;
        s1_next.valid  = s_tvalid;
        s1_next.x      = $signed(s_tdata[POS_W-1:0]);
        s1_next.y      = $signed(s_tdata[2*POS_W-1:POS_W]);
        xx_full        = s1_next.x * s1_next.x;
        yy_full        = s1_next.y * s1_next.y;
        s1_next.xx     = xx_full[SQ_W-1:0];
        s1_next.yy     = yy_full[SQ_W-1:0];
        s1_next.luu    = lu_eff * lu_eff;
        s1_next.lll    = ll_eff * ll_eff;
        s1_next.lul    = lu_eff * ll_eff;
        s1_next.lu     = lu_eff;
        s1_next.ll     = ll_eff;
        s1_next.origin = (s1_next.x == '0) && (s1_next.y == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: numerator of the elbow cosine.
    num_word_t s2_reg;
    num_word_t s2_next;

    always_comb
    begin
        s2_next.valid  = s1_reg.valid;
        s2_next.x      = s1_reg.x;
        s2_next.y      = s1_reg.y;
        s2_next.num    = $signed({2'b00, s1_reg.xx}) + $signed({2'b00, s1_reg.yy})
                       - $signed({3'b000, s1_reg.luu}) - $signed({3'b000, s1_reg.lll});
        s2_next.lul    = s1_reg.lul;
        s2_next.lu     = s1_reg.lu;
        s2_next.ll     = s1_reg.ll;
        s2_next.origin = s1_reg.origin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: magnitude, reach check and the rounded dividend.
    div_word_t        div_reg [0:CM_W];
    div_word_t        div0_next;
    logic [NUM_W-1:0] mag;
    logic [DEN_W-1:0] den;
    logic [NN_W-1:0]  nn;

    always_comb
    begin
        mag = s2_reg.num[NUM_W-1] ? NUM_W'(-s2_reg.num) : NUM_W'(s2_reg.num);
        den = {s2_reg.lul, 1'b0};
        nn  = {1'b0, mag[DEN_W-1:0], FRAC_BITS'(0)} + NN_W'(s2_reg.lul);
        div0_next.valid  = s2_reg.valid;
        div0_next.r      = nn[NN_W-1:CM_W];
        div0_next.nrest  = nn[CM_W-1:0];
        div0_next.q      = '0;
        div0_next.den    = den;
        div0_next.neg    = s2_reg.num[NUM_W-1];
        div0_next.oor    = mag > NUM_W'(den);
        div0_next.lu     = s2_reg.lu;
        div0_next.ll     = s2_reg.ll;
        div0_next.x      = s2_reg.x;
        div0_next.y      = s2_reg.y;
        div0_next.origin = s2_reg.origin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg[0] <= '0;
        end
        else if (adv)
        begin
            div_reg[0] <= div0_next;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar d = 0; d < CM_W; d++)
    begin : g_div
        div_word_t        dv_next;
        logic [DEN_W:0]   trial;
        logic             ge;

        always_comb
        begin
            trial   = {div_reg[d].r, div_reg[d].nrest[CM_W-1]};
            ge      = trial >= {1'b0, div_reg[d].den};
            dv_next = div_reg[d];
            dv_next.r     = ge ? DEN_W'(trial - {1'b0, div_reg[d].den}) : trial[DEN_W-1:0];
            dv_next.nrest = div_reg[d].nrest << 1;
            dv_next.q     = {div_reg[d].q[CM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[d+1] <= '0;
            end
            else if (adv)
            begin
                div_reg[d+1] <= dv_next;
            end
        end
    end

    // Cosine with clamp, its square, and the status code.
    root_word_t          rt_reg [0:CM_W];
    root_word_t          rt0_next;
    logic [CM_W-1:0]     cmag;
    logic [RAD_W:0]      csq;

    always_comb
    begin
        cmag = div_reg[CM_W].oor ? CM_W'(1 << FRAC_BITS) : div_reg[CM_W].q;
        csq  = cmag * cmag;
        rt0_next.valid = div_reg[CM_W].valid;
        rt0_next.rem   = RAD_W'((RAD_W + 1)'(1 << (2 * FRAC_BITS)) - csq);
        rt0_next.root  = '0;
        rt0_next.c     = div_reg[CM_W].neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
        rt0_next.lu    = div_reg[CM_W].lu;
        rt0_next.ll    = div_reg[CM_W].ll;
        rt0_next.x     = div_reg[CM_W].x;
        rt0_next.y     = div_reg[CM_W].y;
        if (div_reg[CM_W].origin)
        begin
            rt0_next.status = STAT_ORIGIN;
        end
        else if (div_reg[CM_W].oor)
        begin
            rt0_next.status = STAT_REACH;
        end
        else
        begin
            rt0_next.status = STAT_SOLVED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_reg[0] <= '0;
        end
        else if (adv)
        begin
            rt_reg[0] <= rt0_next;
        end
    end

    // Integer square root of 1 - c*c, one root bit per stage.
    for (genvar k = 0; k < CM_W; k++)
    begin : g_sqrt
        localparam int B = CM_W - 1 - k;
        root_word_t       rs_next;
        logic [SQT_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            trial   = SQT_W'({rt_reg[k].root, (B + 1)'(0)})
                    + (SQT_W'(1) << (2 * B));
            ge      = SQT_W'(rt_reg[k].rem) >= trial;
            rs_next = rt_reg[k];
            if (ge)
            begin
                rs_next.rem  = RAD_W'(SQT_W'(rt_reg[k].rem) - trial);
                rs_next.root = rt_reg[k].root | CM_W'(1 << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                rt_reg[k+1] <= rs_next;
            end
        end
    end

    // Shoulder coefficients k1 = U + L*c and k2 = L*s.
    k_word_t                k_reg;
    k_word_t                k_next;
    logic signed [K1_W:0]   llc;

    always_comb
    begin
        llc          = $signed({1'b0, rt_reg[CM_W].ll}) * rt_reg[CM_W].c;
        k_next.valid = rt_reg[CM_W].valid;
        k_next.k1    = K1_W'($signed({3'b000, rt_reg[CM_W].lu, FRAC_BITS'(0)}) + llc);
        k_next.k2    = rt_reg[CM_W].ll * rt_reg[CM_W].root;
        k_next.c     = rt_reg[CM_W].c;
        k_next.s     = rt_reg[CM_W].root;
        k_next.x     = rt_reg[CM_W].x;
        k_next.y     = rt_reg[CM_W].y;
        k_next.status = rt_reg[CM_W].status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (adv)
        begin
            k_reg <= k_next;
        end
    end

    // Rotation products of the target by (k1, k2).
    prod_word_t              p_reg;
    prod_word_t              p_next;
    logic signed [K2_W:0]    k2s;

    always_comb
    begin
        k2s          = $signed({1'b0, k_reg.k2});
        p_next.valid = k_reg.valid;
        p_next.p1    = k_reg.y * k_reg.k1;
        p_next.p2    = k_reg.x * k2s;
        p_next.p3    = k_reg.x * k_reg.k1;
        p_next.p4    = k_reg.y * k2s;
        p_next.c     = k_reg.c;
        p_next.s     = k_reg.s;
        p_next.status = k_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else if (adv)
        begin
            p_reg <= p_next;
        end
    end

    // Vectors for both atan2 lanes.
    vec_word_t v_reg;
    vec_word_t v_next;

    always_comb
    begin
        v_next.valid  = p_reg.valid;
        v_next.sy     = CIN_W'(p_reg.p1) - CIN_W'(p_reg.p2);
        v_next.sx     = CIN_W'(p_reg.p3) + CIN_W'(p_reg.p4);
        v_next.ey     = $signed({(CIN_W - CM_W)'(0), p_reg.s});
        v_next.ex     = CIN_W'(p_reg.c);
        v_next.status = p_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    // Two CORDIC lanes with the valid and status carried alongside.
    logic signed [Z_W-1:0] sho_z;
    logic signed [Z_W-1:0] elb_z;

    tlik_atan2 u_sho_atan2 (
        .clk   (clk),
        .en    (adv),
        .y_in  (v_reg.sy),
        .x_in  (v_reg.sx),
        .z_out (sho_z)
    );

    tlik_atan2 u_elb_atan2 (
        .clk   (clk),
        .en    (adv),
        .y_in  (v_reg.ey),
        .x_in  (v_reg.ex),
        .z_out (elb_z)
    );

    side_word_t side_reg [0:CORDIC_LAT];

    assign side_reg[0] = '{valid: v_reg.valid, status: v_reg.status};

    for (genvar j = 0; j < CORDIC_LAT; j++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j+1] <= '0;
            end
            else if (adv)
            begin
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    // Round the Q.30 angles to the output format and clamp them.
    logic signed [Z_W-1:0]  sho_rz;
    logic signed [Z_W-1:0]  elb_rz;
    logic signed [ZQ_W-1:0] sho_q;
    logic signed [ZQ_W-1:0] elb_q;
    logic signed [SHO_W-1:0] sho_next;
    logic [ELB_W-1:0]        elb_next;

    always_comb
    begin
        sho_rz = sho_z + (Z_W'(1) <<< (29 - FRAC_BITS));
        elb_rz = elb_z + (Z_W'(1) <<< (29 - FRAC_BITS));
        sho_q  = ZQ_W'(sho_rz >>> (30 - FRAC_BITS));
        elb_q  = ZQ_W'(elb_rz >>> (30 - FRAC_BITS));
        priority if (side_reg[CORDIC_LAT].status == STAT_ORIGIN)
        begin
            sho_next = '0;
        end
        else if (sho_q > ZQ_W'(PI_QF))
        begin
            sho_next = SHO_W'(PI_QF);
        end
        else if (sho_q < -ZQ_W'(PI_QF))
        begin
            sho_next = -SHO_W'(PI_QF);
        end
        else
        begin
            sho_next = SHO_W'(sho_q);
        end
        priority if (elb_q < 0)
        begin
            elb_next = '0;
        end
        else if (elb_q > ZQ_W'(PI_QF))
        begin
            elb_next = ELB_W'(PI_QF);
        end
        else
        begin
            elb_next = ELB_W'(elb_q);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_sho_reg   <= '0;
            out_elb_reg   <= '0;
            out_stat_reg  <= STAT_SOLVED;
        end
        else if (adv)
        begin
            out_valid_reg <= side_reg[CORDIC_LAT].valid;
            out_sho_reg   <= sho_next;
            out_elb_reg   <= elb_next;
            out_stat_reg  <= side_reg[CORDIC_LAT].status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_elb_reg, out_sho_reg};
    assign m_tuser  = out_stat_reg;

`ifndef SYNTHESIS
    // A target at the origin always reports a zero shoulder angle.
    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_ORIGIN) |-> (m_tdata[SHO_W-1:0] == '0))
        else $error("origin status with nonzero shoulder angle");

    // The elbow angle stays within zero to pi.
    a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[SHO_W+ELB_W-1:SHO_W] <= ELB_W'(PI_QF)))
        else $error("elbow angle beyond pi");

    // The shoulder angle stays within minus pi to pi.
    a_shoulder_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[SHO_W-1:0]) <= SHO_W'(PI_QF))
                  && ($signed(m_tdata[SHO_W-1:0]) >= -SHO_W'(PI_QF)))
        else $error("shoulder angle beyond pi");

    // A clamped cosine leaves the arm straight or folded.
    a_reach_fold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_REACH) |->
            (m_tdata[SHO_W+ELB_W-1:SHO_W] == '0)
            || (m_tdata[SHO_W+ELB_W-1:SHO_W] == ELB_W'(PI_QF)))
        else $error("out of reach without a straight or folded elbow");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics testbench
// Streams target points through the solver under random source gaps and sink
// stalls, predicts each joint angle word, and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import tlik_pkg::*;

    localparam longint ONE_Q     = 64'd1 << FRAC_BITS;
    localparam longint PI_Q30_L  = 64'd3373259426;
    localparam int     DRAIN_CYC = 90;
    localparam int     LIMIT_CYC = 600000;
    localparam int     HOLD_CYC  = 400;

    // Arctangent of 2^-i in Q.30 radians, first eleven steps.
    localparam longint ATAN_Q30 [0:10] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775852, 8388437, 4194283, 2097149, 1048576
    };

    typedef struct {
        logic signed [SHO_W-1:0] shoulder;
        logic [ELB_W-1:0]        elbow;
        status_t                 status;
    } angles_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    // Predictor copy of the link length registers.
    logic [LEN_W-1:0] upper_len;
    logic [LEN_W-1:0] lower_len;

    angles_t angle_queue[$];
    int      mismatch_count;
    int      words_sent;
    int      words_checked;
    int      reach_count;
    int      origin_count;
    int      cycle_count;
    bit      no_idle;
    bit      hold_sink;

    two_link_inverse_kinematics_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Run time limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYC)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC atan2 with a Q.30 angle.
    function automatic longint cordic_angle(input longint vy, input longint vx);
        longint z;
        longint xs;
        longint ys;
        longint step;
        z = 0;
        if (vx == 0 && vy == 0)
            return 0;
        while ((vx < 0 ? -vx : vx) < (64'sd1 <<< 50) && (vy < 0 ? -vy : vy) < (64'sd1 <<< 50))
        begin
            vx = vx * 2;
            vy = vy * 2;
        end
        // Left half-plane: rotate by pi first.
        if (vx < 0)
        begin
            z = (vy >= 0) ? PI_Q30_L : -PI_Q30_L;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            step = (i < 11) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
            if (vy >= 0)
            begin
                vx += ys;
                vy -= xs;
                z += step;
            end
            else
            begin
                vx -= ys;
                vy += xs;
                z -= step;
            end
        end
        return z;
    endfunction

    function automatic longint to_output_angle(input longint z);
        return (z + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    // Joint angles and status for one target under the current link lengths.
    function automatic angles_t solve_joints(input logic signed [POS_W-1:0] tx,
                                             input logic signed [POS_W-1:0] ty);
        angles_t res;
        longint  x;
        longint  y;
        longint  lu;
        longint  ll;
        longint  num;
        longint  den;
        longint  mag;
        longint  c;
        longint  s;
        longint  k1;
        longint  k2;
        longint  elb;
        longint  sho;
        longint  pi_q;
        status_t st;
        x = tx;
        y = ty;
        lu = (upper_len == 0) ? 1 : upper_len;
        ll = (lower_len == 0) ? 1 : lower_len;
        pi_q = to_output_angle(PI_Q30_L);
        num = x * x + y * y - lu * lu - ll * ll;
        den = 2 * lu * ll;
        mag = (num < 0) ? -num : num;
        st = STAT_SOLVED;
        // Elbow cosine, clamped when the target is out of reach.
        if (mag > den)
        begin
            st = STAT_REACH;
            c = (num < 0) ? -ONE_Q : ONE_Q;
        end
        else
        begin
            c = ((mag <<< FRAC_BITS) + den / 2) / den;
            if (num < 0)
                c = -c;
        end
        s = floor_sqrt(ONE_Q * ONE_Q - c * c);
        elb = to_output_angle(cordic_angle(s, c));
        if (elb < 0)
            elb = 0;
        if (elb > pi_q)
            elb = pi_q;
        if (x == 0 && y == 0)
        begin
            sho = 0;
            st = STAT_ORIGIN;
        end
        else
        begin
            k1 = lu * ONE_Q + ll * c;
            k2 = ll * s;
            sho = to_output_angle(cordic_angle(y * k1 - x * k2, x * k1 + y * k2));
            if (sho > pi_q)
                sho = pi_q;
            if (sho < -pi_q)
                sho = -pi_q;
        end
        res.shoulder = sho[SHO_W-1:0];
        res.elbow = elb[ELB_W-1:0];
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        angles_t exp_angles;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (angle_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h/%h", m_tdata, m_tuser));
            end
            else
            begin
                exp_angles = angle_queue.pop_front();
                if (m_tdata[14:0] !== exp_angles.shoulder)
                    report_mismatch($sformatf("shoulder %0d, expected %0d",
                        $signed(m_tdata[14:0]), exp_angles.shoulder));
                if (m_tdata[28:15] !== exp_angles.elbow)
                    report_mismatch($sformatf("elbow %0d, expected %0d",
                        m_tdata[28:15], exp_angles.elbow));
                if (m_tdata[31:29] !== 3'b000)
                    report_mismatch("padding bits of m_tdata not zero");
                if (m_tuser !== exp_angles.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_tuser, exp_angles.status));
            end
        end
    end

    // Sink side: random stalls per word, and one long hold-off on request.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
                hold_sink = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Send one target word and record its expected angles.
    task automatic send_target(input logic signed [POS_W-1:0] tx,
                               input logic signed [POS_W-1:0] ty);
        int gap;
        angles_t exp_angles;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ty, tx};
        do @(posedge clk); while (!s_tready);
        exp_angles = solve_joints(tx, ty);
        if (exp_angles.status == STAT_REACH)
            reach_count++;
        if (exp_angles.status == STAT_ORIGIN)
            origin_count++;
        angle_queue.push_back(exp_angles);
        words_sent++;
    endtask

    // Let the pipeline empty before a register write or the end of the run.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_links(input logic [LEN_W-1:0] upper, input logic [LEN_W-1:0] lower);
        drain_pipeline();
        cfg_we <= 1'b1;
        cfg_index <= REG_UPPER;
        cfg_data <= upper;
        @(posedge clk);
        cfg_index <= REG_LOWER;
        cfg_data <= lower;
        @(posedge clk);
        cfg_we <= 1'b0;
        upper_len = upper;
        lower_len = lower;
    endtask

    // Random target, mostly inside or near the reachable annulus.
    task automatic send_random_target();
        int reach;
        int kind;
        int tx;
        int ty;
        reach = int'(upper_len) + int'(lower_len) + 64;
        if (reach > 32767)
            reach = 32767;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            tx = $urandom_range(0, 2 * reach) - reach;
            ty = $urandom_range(0, 2 * reach) - reach;
        end
        else if (kind < 90)
        begin
            tx = $signed(16'($urandom));
            ty = $signed(16'($urandom));
        end
        else if (kind < 95)
        begin
            tx = 0;
            ty = $urandom_range(0, 2 * reach) - reach;
        end
        else
        begin
            tx = $urandom_range(0, 2 * reach) - reach;
            ty = (kind == 99) ? 0 : $urandom_range(0, 2) - 1;
        end
        send_target(16'(tx), 16'(ty));
    endtask

    task automatic test_directed_reset_links();
        send_target(16'sd0, 16'sd0);
        send_target(16'sd32767, 16'sd32767);
        send_target(-16'sd32768, -16'sd32768);
        send_target(-16'sd32768, 16'sd0);
        send_target(16'sd0, 16'sd32767);
        send_target(16'sd6144, 16'sd0);
        send_target(16'sd2048, 16'sd0);
        send_target(16'sd0, -16'sd4096);
        send_target(-16'sd6144, 16'sd0);
        send_target(-16'sd4096, -16'sd1);
        send_target(-16'sd4096, 16'sd1);
        send_target(16'sd3000, 16'sd3000);
        send_target(16'sd1, 16'sd0);
        send_target(16'sd6145, 16'sd0);
        send_target(16'sd2047, 16'sd0);
    endtask

    // Equal links: a target next to the origin folds the arm, so both
    // shoulder terms vanish.
    task automatic test_folded_arm();
        set_links(15'd4096, 15'd4096);
        send_target(16'sd1, 16'sd0);
        send_target(16'sd0, -16'sd1);
        send_target(16'sd0, 16'sd0);
        send_target(16'sd8192, 16'sd0);
        for (int i = 0; i < 150; i++)
            send_random_target();
    endtask

    task automatic test_random_links(input logic [LEN_W-1:0] upper,
                                     input logic [LEN_W-1:0] lower, input int count);
        set_links(upper, lower);
        send_target(16'sd0, 16'sd0);
        send_target(16'sd32767, -16'sd32768);
        for (int i = 0; i < count; i++)
        begin
            // Alternate stretches without idling.
            no_idle = (i % 100) >= 80;
            send_random_target();
        end
        no_idle = 1'b0;
    endtask

    // Sink holds off while the source keeps offering words back to back.
    task automatic test_backpressure();
        set_links(15'd4096, 15'd2048);
        hold_sink = 1'b1;
        no_idle = 1'b1;
        for (int i = 0; i < 160; i++)
            send_random_target();
        no_idle = 1'b0;
    endtask

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_UPPER;
        cfg_data = '0;
        upper_len = UPPER_RESET;
        lower_len = LOWER_RESET;
        mismatch_count = 0;
        words_sent = 0;
        words_checked = 0;
        reach_count = 0;
        origin_count = 0;
        no_idle = 1'b0;
        hold_sink = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reset_links();
        test_folded_arm();
        test_random_links(15'd4096, 15'd2048, 220);
        test_random_links(15'd1, 15'd1, 160);
        test_random_links(15'd0, 15'd0, 100);
        test_random_links(15'd32767, 15'd32767, 160);
        test_random_links(15'd32767, 15'd1, 160);
        test_random_links(15'd1, 15'd32767, 160);
        test_random_links(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)), 200);
        test_random_links(15'($urandom_range(1, 8192)), 15'($urandom_range(1, 8192)), 200);
        test_backpressure();
        drain_pipeline();

        $display("Covered %0d targets over nine link settings, %0d out of reach, %0d at origin.",
            words_sent, reach_count, origin_count);
        $display("Checked %0d result words under random stalls and one long sink hold-off.",
            words_checked);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
